// ===== rtl/hlc_pkg.sv =====
// Shared types and constants for the homogeneous line clipper.
`timescale 1ns / 1ps
package hlc_pkg;

  // Default fraction bits of the clip-space and NDC coordinates
  localparam int FRAC_BITS_DEF = 16;
  // Fraction bits of the clip parameter t (1.0 = 2^T_BITS)
  localparam int T_BITS = 30;
  localparam int COORD_W = 32;
  localparam int OUT_W = 18;
  // Entries in the queue between front and back
  localparam int QDEPTH = 4;

  localparam logic [T_BITS:0] T_ONE = {1'b1, {T_BITS{1'b0}}};
  localparam logic [T_BITS:0] T_ZERO = '0;

  typedef logic signed [COORD_W-1:0] coord_t;
  typedef logic [T_BITS:0] tval_t;
  typedef logic signed [OUT_W-1:0] ndc_t;

  // One classified segment: endpoints, parameter bounds and reject mark
  typedef struct packed {
    coord_t [3:0] a;
    coord_t [3:0] b;
    tval_t        tmin;
    tval_t        tmax;
    logic         reject;
  } seg_t;

endpackage

// ===== rtl/hlc_frac_div.sv =====
// Pipelined restoring divider for a fraction num/den with num < den, one quotient bit a stage.
`timescale 1ns / 1ps
module hlc_frac_div #(
  parameter int DW = 34,
  parameter int QB = 30
) (
  input  logic          clk,
  input  logic          en,
  input  logic [DW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QB-1:0] quo
);

  logic [DW-1:0] rem [QB];
  logic [DW-1:0] dvs [QB];
  logic [QB-1:0] qt  [QB];

  genvar k;
  generate
    for (k = 0; k < QB; k++) begin : g_stage
      logic [DW-1:0] rin;
      logic [DW-1:0] din;
      logic [QB-1:0] qin;
      logic [DW:0]   r2;
      logic          ge;

      if (k == 0) begin : g_first
        assign rin = num;
        assign din = den;
        assign qin = '0;
      end else begin : g_next
        assign rin = rem[k-1];
        assign din = dvs[k-1];
        assign qin = qt[k-1];
      end

      // Double the remainder and try a subtract
      assign r2 = {rin, 1'b0};
      assign ge = (r2 >= {1'b0, din});

      always_ff @(posedge clk) begin
        if (en) begin
          rem[k] <= ge ? DW'(r2 - {1'b0, din}) : DW'(r2);
          dvs[k] <= din;
          qt[k]  <= {qin[QB-2:0], ge};
        end
      end
    end
  endgenerate

  assign quo = qt[QB-1];

endmodule

// ===== rtl/hlc_front.sv =====
// Front end: plane terms, classification, parameter divides and t bounds per segment.
`timescale 1ns / 1ps
module hlc_front (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  hlc_pkg::coord_t [7:0] in_pts,
  output logic                  out_valid,
  input  logic                  out_ready,
  output hlc_pkg::seg_t         out_seg
);
  import hlc_pkg::*;

  localparam int NP = 6;
  localparam int DW = 34;
  localparam int TQ = T_BITS;

  typedef struct packed {
    coord_t [3:0]  a;
    coord_t [3:0]  b;
    logic [NP-1:0] rej;
    logic [NP-1:0] min_one;
    logic [NP-1:0] min_div;
    logic [NP-1:0] max_zero;
    logic [NP-1:0] max_div;
  } side_t;

  logic en;
  logic v0, v1, v2, v3;
  logic [TQ-1:0] vd;

  coord_t [3:0] a0, b0, a1, b1, a3, b3;
  logic signed [34:0] n1 [NP];
  logic signed [34:0] m1 [NP];
  logic signed [34:0] nc [NP];
  logic signed [34:0] mc [NP];
  side_t s2, s2_next;
  logic [DW-1:0] num2 [NP];
  logic [DW-1:0] den2 [NP];
  logic [DW-1:0] num_next [NP];
  logic [DW-1:0] den_next [NP];
  side_t sd [TQ];
  logic [T_BITS-1:0] quo [NP];
  tval_t tmin3, tmax3, tmin_next, tmax_next;
  logic rej3;

  // Whole front advances together; hold when the queue is full
  assign en = !v3 || out_ready;
  assign in_ready = en;

  // Valid chain
  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      vd <= '0;
      v3 <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      vd <= {vd[TQ-2:0], v2};
      v3 <= vd[TQ-1];
    end
  end

  // Capture the beat
  always_ff @(posedge clk) begin
    if (en) begin
      a0 <= in_pts[3:0];
      b0 <= in_pts[7:4];
    end
  end

  // Form N and M for the six planes; planes 0..2 are c <= w, 3..5 are -w <= c
  always_comb begin
    logic signed [34:0] ai, bi, aw, bw;
    for (int si = 0; si < 2; si++) begin
      for (int ax = 0; ax < 3; ax++) begin
        ai = 35'($signed(a0[ax]));
        bi = 35'($signed(b0[ax]));
        aw = 35'($signed(a0[3]));
        bw = 35'($signed(b0[3]));
        if (si == 1) begin
          nc[si*3+ax] = (bi - ai) + (bw - aw);
          mc[si*3+ax] = -ai - aw;
        end else begin
          nc[si*3+ax] = (ai - bi) + (bw - aw);
          mc[si*3+ax] = ai - aw;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a1 <= a0;
      b1 <= b0;
      for (int p = 0; p < NP; p++) begin
        n1[p] <= nc[p];
        m1[p] <= mc[p];
      end
    end
  end

  // Classify each plane and set up the ratio divides
  always_comb begin
    logic nz, nneg, npos, mpos, mneg, mge, mgt;
    logic signed [34:0] mabs, nabs;
    s2_next.a = a1;
    s2_next.b = b1;
    for (int p = 0; p < NP; p++) begin
      nz   = (n1[p] == '0);
      nneg = n1[p][34];
      npos = !nneg && !nz;
      mneg = m1[p][34];
      mpos = !mneg && (m1[p] != '0);
      mge  = (m1[p] >= n1[p]);
      mgt  = (m1[p] > n1[p]);
      s2_next.rej[p]      = nz && mpos;
      s2_next.min_one[p]  = npos && mge;
      s2_next.min_div[p]  = npos && mpos && !mge;
      s2_next.max_zero[p] = nneg && !mneg;
      s2_next.max_div[p]  = nneg && mneg && mgt;
      mabs = mneg ? -m1[p] : m1[p];
      nabs = nneg ? -n1[p] : n1[p];
      num_next[p] = (s2_next.min_div[p] || s2_next.max_div[p]) ? DW'(mabs) : '0;
      den_next[p] = DW'(nabs);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2 <= s2_next;
      for (int p = 0; p < NP; p++) begin
        num2[p] <= num_next[p];
        den2[p] <= den_next[p];
      end
    end
  end

  // Ratio dividers, |M| * 2^T_BITS / |N|
  genvar g;
  generate
    for (g = 0; g < NP; g++) begin : g_div
      hlc_frac_div #(
        .DW(DW),
        .QB(T_BITS)
      ) u_div (
        .clk (clk),
        .en  (en),
        .num (num2[g]),
        .den (den2[g]),
        .quo (quo[g])
      );
    end
  endgenerate

  // Carry the segment alongside the dividers
  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= s2;
      for (int k = 1; k < TQ; k++) begin
        sd[k] <= sd[k-1];
      end
    end
  end

  // Raise tMin and lower tMax over the planes
  always_comb begin
    tmin_next = (|sd[TQ-1].min_one) ? T_ONE : T_ZERO;
    tmax_next = (|sd[TQ-1].max_zero) ? T_ZERO : T_ONE;
    for (int p = 0; p < NP; p++) begin
      if (sd[TQ-1].min_div[p] && ({1'b0, quo[p]} > tmin_next)) begin
        tmin_next = {1'b0, quo[p]};
      end
      if (sd[TQ-1].max_div[p] && ({1'b0, quo[p]} < tmax_next)) begin
        tmax_next = {1'b0, quo[p]};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a3    <= sd[TQ-1].a;
      b3    <= sd[TQ-1].b;
      tmin3 <= tmin_next;
      tmax3 <= tmax_next;
      rej3  <= |sd[TQ-1].rej;
    end
  end

  assign out_valid      = v3;
  assign out_seg.a      = a3;
  assign out_seg.b      = b3;
  assign out_seg.tmin   = tmin3;
  assign out_seg.tmax   = tmax3;
  assign out_seg.reject = rej3 || (tmin3 >= tmax3);

endmodule

// ===== rtl/hlc_queue.sv =====
// Short queue of classified segments between front and back.
`timescale 1ns / 1ps
module hlc_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  hlc_pkg::seg_t in_seg,
  output logic          out_valid,
  input  logic          out_ready,
  output hlc_pkg::seg_t out_seg
);
  import hlc_pkg::*;

  localparam int AW = $clog2(QDEPTH);

  seg_t mem [QDEPTH];
  logic [AW-1:0] wp, rp;
  logic [AW:0] cnt;
  logic push, pop;

  assign in_ready  = (cnt != (AW+1)'(QDEPTH));
  assign out_valid = (cnt != '0);
  assign push = in_valid && in_ready;
  assign pop  = out_valid && out_ready;
  assign out_seg = mem[rp];

  // Store the beat
  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp] <= in_seg;
    end
  end

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) begin
        wp <= (wp == AW'(QDEPTH-1)) ? '0 : wp + 1'b1;
      end
      if (pop) begin
        rp <= (rp == AW'(QDEPTH-1)) ? '0 : rp + 1'b1;
      end
      if (push && !pop) begin
        cnt <= cnt + 1'b1;
      end else if (pop && !push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

endmodule

// ===== rtl/hlc_back.sv =====
// Back end: endpoint interpolation, perspective divide and output register.
`timescale 1ns / 1ps
module hlc_back #(
  parameter int FRAC_BITS = hlc_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  hlc_pkg::seg_t       in_seg,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_kept,
  output hlc_pkg::ndc_t [5:0] out_coord
);
  import hlc_pkg::*;

  localparam int NC = 6;
  localparam int DW = 32;

  typedef struct packed {
    logic          rej;
    logic [NC-1:0] sat;
    logic [NC-1:0] wz;
    logic [NC-1:0] neg;
  } side_t;

  logic en;
  logic v0, v1, v2, v3;
  logic [FRAC_BITS-1:0] vd;

  coord_t [3:0] a0, a1;
  logic signed [32:0] d0 [4];
  tval_t t0 [2];
  logic rej0, rej1, rej2;
  logic signed [63:0] prod1 [8];
  coord_t p2 [8];
  logic [DW-1:0] num3 [NC];
  logic [DW-1:0] den3 [NC];
  side_t s3, s3_next;
  logic [DW-1:0] num_next [NC];
  logic [DW-1:0] den_next [NC];
  side_t sd [FRAC_BITS];
  logic [FRAC_BITS-1:0] quo [NC];
  ndc_t [5:0] coord_next;

  function automatic logic [DW-1:0] mag32(input coord_t v);
    return v[COORD_W-1] ? DW'(~v + 1'b1) : DW'(v);
  endfunction

  // Back advances together; hold while the output beat waits
  assign en = !out_valid || out_ready;
  assign in_ready = en;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      vd <= '0;
      out_valid <= 1'b0;
    end else if (en) begin
      v0 <= in_valid;
      v1 <= v0;
      v2 <= v1;
      v3 <= v2;
      vd <= {vd[FRAC_BITS-2:0], v3};
      out_valid <= vd[FRAC_BITS-1];
    end
  end

  // Take the segment and its deltas
  always_ff @(posedge clk) begin
    if (en) begin
      a0    <= in_seg.a;
      t0[0] <= in_seg.tmin;
      t0[1] <= in_seg.tmax;
      rej0  <= in_seg.reject;
      for (int k = 0; k < 4; k++) begin
        d0[k] <= 33'($signed(in_seg.b[k])) - 33'($signed(in_seg.a[k]));
      end
    end
  end

  // Delta times t, both endpoints
  always_ff @(posedge clk) begin
    if (en) begin
      a1   <= a0;
      rej1 <= rej0;
      for (int e = 0; e < 2; e++) begin
        for (int k = 0; k < 4; k++) begin
          prod1[e*4+k] <= 64'(d0[k] * $signed({1'b0, t0[e]}));
        end
      end
    end
  end

  // Add the floored step to the start point
  always_ff @(posedge clk) begin
    if (en) begin
      rej2 <= rej1;
      for (int e = 0; e < 2; e++) begin
        for (int k = 0; k < 4; k++) begin
          p2[e*4+k] <= COORD_W'(34'($signed(a1[k])) + 34'(prod1[e*4+k] >>> T_BITS));
        end
      end
    end
  end

  // Split each component into sign, magnitude and saturation
  always_comb begin
    logic [DW-1:0] cab, wab;
    s3_next.rej = rej2;
    for (int e = 0; e < 2; e++) begin
      for (int k = 0; k < 3; k++) begin
        cab = mag32(p2[e*4+k]);
        wab = mag32(p2[e*4+3]);
        s3_next.sat[e*3+k] = (cab >= wab);
        s3_next.wz[e*3+k]  = (p2[e*4+3] == '0);
        s3_next.neg[e*3+k] = p2[e*4+k][COORD_W-1] ^ p2[e*4+3][COORD_W-1];
        num_next[e*3+k] = (cab >= wab) ? '0 : cab;
        den_next[e*3+k] = wab;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3 <= s3_next;
      for (int j = 0; j < NC; j++) begin
        num3[j] <= num_next[j];
        den3[j] <= den_next[j];
      end
    end
  end

  // Perspective dividers, |c| * 2^FRAC_BITS / |w|
  genvar g;
  generate
    for (g = 0; g < NC; g++) begin : g_div
      hlc_frac_div #(
        .DW(DW),
        .QB(FRAC_BITS)
      ) u_div (
        .clk (clk),
        .en  (en),
        .num (num3[g]),
        .den (den3[g]),
        .quo (quo[g])
      );
    end
  endgenerate

  always_ff @(posedge clk) begin
    if (en) begin
      sd[0] <= s3;
      for (int k = 1; k < FRAC_BITS; k++) begin
        sd[k] <= sd[k-1];
      end
    end
  end

  // Clamp, apply sign, drop rejected segments and zero w
  always_comb begin
    logic [FRAC_BITS:0] mag;
    logic signed [FRAC_BITS+1:0] val;
    for (int j = 0; j < NC; j++) begin
      mag = sd[FRAC_BITS-1].sat[j] ? {1'b1, {FRAC_BITS{1'b0}}} : {1'b0, quo[j]};
      val = sd[FRAC_BITS-1].neg[j] ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
      coord_next[j] = (sd[FRAC_BITS-1].rej || sd[FRAC_BITS-1].wz[j]) ? '0 : OUT_W'(val);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_kept  <= !sd[FRAC_BITS-1].rej;
      out_coord <= coord_next;
    end
  end

endmodule

// ===== rtl/homogeneous_line_clipper_top.sv =====
// Top level of the homogeneous line clipper.
//
//  Channel  Dir  Width  Carries
//  s_*      in   256    one segment: start x,y,z,w then end x,y,z,w (Q16.16)
//  m_*      out  112+1  clipped NDC near x,y,z, far x,y,z; kept flag in tuser
//
// One segment a clock, sustained while the output is not stalled. The depth is set by
// the bit-a-stage dividers: 30 stages for the t ratios, FRAC_BITS for the NDC divide.
// Reset clears every valid bit and empties the queue; no clearing pass.
// An output stall freezes the back end; the four-entry queue lets the front keep
// accepting until it fills, then s_tready drops.
`timescale 1ns / 1ps
module homogeneous_line_clipper_top #(
  parameter int FRAC_BITS = hlc_pkg::FRAC_BITS_DEF
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // start_x, start_y, start_z, start_w, end_x, end_y, end_z, end_w (32 bits each)
  input  logic [255:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // near_end_x, near_end_y, near_end_z, far_end_x, far_end_y, far_end_z (18 bits each), 4 pad
  output logic [111:0] m_tdata,
  // kept
  output logic [0:0]   m_tuser
);
  import hlc_pkg::*;

  logic q_in_valid, q_in_ready, q_out_valid, q_out_ready;
  seg_t q_in_seg, q_out_seg;
  logic kept;
  ndc_t [5:0] coord;

  hlc_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_pts    (s_tdata),
    .out_valid (q_in_valid),
    .out_ready (q_in_ready),
    .out_seg   (q_in_seg)
  );

  hlc_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_in_valid),
    .in_ready  (q_in_ready),
    .in_seg    (q_in_seg),
    .out_valid (q_out_valid),
    .out_ready (q_out_ready),
    .out_seg   (q_out_seg)
  );

  hlc_back #(
    .FRAC_BITS(FRAC_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (q_out_valid),
    .in_ready  (q_out_ready),
    .in_seg    (q_out_seg),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_kept  (kept),
    .out_coord (coord)
  );

  // Pack the result beat
  assign m_tdata = {4'b0000, coord};
  assign m_tuser = kept;

endmodule

// ===== rtl/hlc_checker.sv =====
// Port checks for the homogeneous line clipper, bound to the top level.
`timescale 1ns / 1ps
module hlc_checker (
  input logic         clk,
  input logic         rst,
  input logic         m_tvalid,
  input logic         m_tready,
  input logic [111:0] m_tdata,
  input logic [0:0]   m_tuser
);

  // A waiting result beat stays until taken
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid)
    else $error("result beat dropped while stalled");

  // A rejected segment carries all-zero coordinates
  a_reject_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[0] |-> m_tdata == '0)
    else $error("rejected segment with nonzero coordinates");

  // Reset leaves no result pending
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result valid straight after reset");

endmodule

bind homogeneous_line_clipper_top hlc_checker u_chk (.*);

// ===== sim/homogeneous_line_clipper_top_test.sv =====
// Self-checking testbench for the homogeneous line clipper, stream in and stream out.
`timescale 1ns / 1ps
module homogeneous_line_clipper_top_test;
  import hlc_pkg::*;

  localparam int FRAC = FRAC_BITS_DEF;
  localparam int TB = T_BITS;
  localparam longint UNIT_T = 64'sd1 <<< TB;
  localparam longint ONE_Q = 64'sd1 <<< FRAC;
  localparam int IDLE_LIMIT = 5000;
  localparam int RANDOM_SEGS = 750;
  localparam int PAUSE_AT = 300;

  // kept flag and NDC near x,y,z then far x,y,z
  typedef struct packed {
    logic kept;
    ndc_t [5:0] crd;
  } clip_res_t;

  typedef struct {
    logic [255:0] seg;
    bit           known;
    clip_res_t    want;
  } seg_item_t;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [255:0] s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic [111:0] m_tdata;
  logic [0:0]   m_tuser;

  seg_item_t  seg_q[$];
  clip_res_t  clipped_q[$];
  int         errors = 0;
  int         sent = 0;
  bit         pause_pending = 1'b0;
  bit         pause_done = 1'b0;
  int         idle_cycles = 0;
  int         send_gap = 0;
  int         take_gap = 0;
  bit         calm_send = 1'b0;
  bit         calm_take = 1'b0;
  seg_item_t  cur_item;

  homogeneous_line_clipper_top i_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
  );

  always #6 clk = ~clk;

  // Point on the segment at parameter t, rounded down to Q.FRAC
  function automatic longint point_at(longint a, longint b, longint t);
    return (a * UNIT_T + (b - a) * t) >>> TB;
  endfunction

  // Perspective divide, truncated and saturated to +-1.0
  function automatic ndc_t divide_w(longint c, longint w);
    longint q;
    if (w == 0) return '0;
    q = (c * ONE_Q) / w;
    if (q > ONE_Q) q = ONE_Q;
    if (q < -ONE_Q) q = -ONE_Q;
    return ndc_t'(q);
  endfunction

  // Clip one segment against the six view planes and project both ends
  function automatic clip_res_t clip_segment(logic [255:0] d);
    longint a[4];
    longint b[4];
    longint tlo, thi, n, m, s, q, pw;
    bit rej;
    clip_res_t r;
    r = '0;
    tlo = 0;
    thi = UNIT_T;
    rej = 1'b0;
    for (int k = 0; k < 4; k++) begin
      a[k] = coord_t'(d[32*k +: 32]);
      b[k] = coord_t'(d[32*(k+4) +: 32]);
    end
    for (int si = 0; si < 2; si++) begin
      s = si ? 1 : -1;
      for (int i = 0; i < 3; i++) begin
        n = s * (b[i] - a[i]) + (b[3] - a[3]);
        m = -(s * a[i] + a[3]);
        if (n == 0) begin
          if (m > 0) rej = 1'b1;
        end else if (n > 0) begin
          if (m >= n) tlo = UNIT_T;
          else if (m > 0) begin
            q = (m <<< TB) / n;
            if (q > tlo) tlo = q;
          end
        end else begin
          if (m >= 0) thi = 0;
          else if (m > n) begin
            q = ((-m) <<< TB) / (-n);
            if (q < thi) thi = q;
          end
        end
      end
    end
    if (tlo >= thi || rej) return r;
    r.kept = 1'b1;
    pw = point_at(a[3], b[3], tlo);
    for (int i = 0; i < 3; i++) r.crd[i] = divide_w(point_at(a[i], b[i], tlo), pw);
    pw = point_at(a[3], b[3], thi);
    for (int i = 0; i < 3; i++) r.crd[3+i] = divide_w(point_at(a[i], b[i], thi), pw);
    return r;
  endfunction

  function automatic logic [255:0] pack_seg(int ax, int ay, int az, int aw,
                                            int bx, int by, int bz, int bw);
    return {bw, bz, by, bx, aw, az, ay, ax};
  endfunction

  function automatic clip_res_t typed_res(bit k, int nx, int ny, int nz,
                                          int fx, int fy, int fz);
    clip_res_t r;
    r.kept = k;
    r.crd = {ndc_t'(fz), ndc_t'(fy), ndc_t'(fx), ndc_t'(nz), ndc_t'(ny), ndc_t'(nx)};
    return r;
  endfunction

  function automatic int gap_len();
    int p;
    p = $urandom_range(0, 99);
    if (p < 65) return 0;
    if (p < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Coordinate within twice |w| either side of zero
  function automatic int near_w(int w);
    int h;
    h = (w < 0) ? -w : w;
    return int'($urandom_range(0, 4 * h)) - 2 * h;
  endfunction

  // Drive segments; predict each one as its beat is taken
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (!s_tvalid || s_tready) begin
      if (s_tvalid) begin
        clipped_q = {clipped_q,
                     cur_item.known ? cur_item.want : clip_segment(cur_item.seg)};
        sent++;
        if (sent % 100 == 0) calm_send = ~calm_send;
        if (sent == PAUSE_AT) pause_pending = 1'b1;
        send_gap = calm_send ? 0 : gap_len();
      end
      if (pause_pending && clipped_q.size() == 0) begin
        pause_pending = 1'b0;
        pause_done = 1'b1;
      end
      if (send_gap > 0) begin
        send_gap--;
        s_tvalid <= 1'b0;
      end else if (pause_pending || seg_q.size() == 0) begin
        s_tvalid <= 1'b0;
      end else begin
        cur_item = seg_q.pop_front();
        s_tvalid <= 1'b1;
        s_tdata <= cur_item.seg;
      end
    end
  end

  // Stall the result side and check every beat against the oldest prediction
  always @(posedge clk) begin
    clip_res_t got, want;
    if (!rst && m_tvalid && m_tready) begin
      got.kept = m_tuser[0];
      for (int k = 0; k < 6; k++) got.crd[k] = m_tdata[18*k +: 18];
      if (clipped_q.size() == 0) begin
        $display("%0t: unexpected result beat, actual kept %0d", $time, got.kept);
        errors++;
      end else begin
        want = clipped_q.pop_front();
        if (want.kept !== got.kept) begin
          $display("%0t: kept expected %0d actual %0d", $time, want.kept, got.kept);
          errors++;
        end
        for (int k = 0; k < 6; k++)
          if (want.crd[k] !== got.crd[k]) begin
            $display("%0t: coord %0d expected %0d actual %0d", $time, k,
                     want.crd[k], got.crd[k]);
            errors++;
          end
      end
    end
    if (!rst && (m_tvalid && m_tready || s_tvalid && s_tready)) idle_cycles = 0;
    else idle_cycles++;
    if (take_gap > 0) begin
      take_gap--;
      m_tready <= 1'b0;
    end else begin
      if ($urandom_range(0, 199) == 0) calm_take = ~calm_take;
      take_gap = calm_take ? 0 : gap_len();
      m_tready <= (take_gap == 0);
    end
  end

  // Watchdog on cycles without any beat
  always @(posedge clk) begin
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    seg_item_t it;
    int w, p;
    // Directed rows: known results where they are obvious
    it.known = 1'b1;
    it.seg = '0; it.want = typed_res(1, 0, 0, 0, 0, 0, 0); seg_q = {seg_q, it};
    it.seg = pack_seg(0, 0, 0, 65536, 0, 0, 0, 65536);
    it.want = typed_res(1, 0, 0, 0, 0, 0, 0); seg_q = {seg_q, it};
    it.seg = pack_seg(32768, 0, 0, 65536, -32768, 0, 0, 65536);
    it.want = typed_res(1, 32768, 0, 0, -32768, 0, 0); seg_q = {seg_q, it};
    it.seg = pack_seg(0, 0, 0, 65536, 131072, 0, 0, 65536);
    it.want = typed_res(1, 0, 0, 0, 65536, 0, 0); seg_q = {seg_q, it};
    it.seg = pack_seg(0, 0, 0, 65536, 0, -131072, 0, 65536);
    it.want = typed_res(1, 0, 0, 0, 0, -65536, 0); seg_q = {seg_q, it};
    it.seg = pack_seg(131072, 0, 0, 65536, 131072, 0, 0, 65536);
    it.want = typed_res(0, 0, 0, 0, 0, 0, 0); seg_q = {seg_q, it};
    it.seg = pack_seg(0, 0, -131072, 65536, 0, 0, -131072, 65536);
    it.want = typed_res(0, 0, 0, 0, 0, 0, 0); seg_q = {seg_q, it};
    it.seg = pack_seg(0, 0, 0, -65536, 0, 0, 0, -65536);
    it.want = typed_res(0, 0, 0, 0, 0, 0, 0); seg_q = {seg_q, it};
    // Extremes and awkward shapes, left to the predictor
    it.known = 1'b0;
    it.seg = {256{1'b1}} ^ {8{32'h8000_0000}}; seg_q = {seg_q, it};
    it.seg = {8{32'h8000_0000}}; seg_q = {seg_q, it};
    it.seg = {{4{32'h7fff_ffff}}, {4{32'h8000_0000}}}; seg_q = {seg_q, it};
    it.seg = {{4{32'h8000_0000}}, {4{32'h7fff_ffff}}}; seg_q = {seg_q, it};
    it.seg = {32'h7fff_ffff, 96'h0, 32'h7fff_ffff, 96'h0}; seg_q = {seg_q, it};
    it.seg = {32'h7fff_ffff, {3{32'h8000_0000}}, 32'h7fff_ffff, {3{32'h7fff_ffff}}};
    seg_q = {seg_q, it};
    it.seg = pack_seg(-65536, 65536, 65536, 65536, 65536, -65536, -65536, 65536);
    seg_q = {seg_q, it};
    it.seg = pack_seg(100000, 3000, -5000, 65536, -90000, 2000, 7000, 70000);
    seg_q = {seg_q, it};
    it.seg = pack_seg(0, 0, 0, 1, 1, 0, 0, 1); seg_q = {seg_q, it};
    it.seg = pack_seg(65536, 0, 0, 65536, 65537, 0, 0, 65536); seg_q = {seg_q, it};
    it.seg = pack_seg(0, 0, 0, 65536, 0, 0, 0, -65536); seg_q = {seg_q, it};
    it.seg = pack_seg(3, 0, 0, 1, -3, 0, 0, 1); seg_q = {seg_q, it};
    // Random segments: mostly near the view volume, some raw noise
    for (int n = 0; n < RANDOM_SEGS; n++) begin
      p = $urandom_range(0, 99);
      if (p < 30) begin
        for (int k = 0; k < 8; k++) it.seg[32*k +: 32] = $urandom;
      end else begin
        w = int'($urandom_range(1, 1 << 20));
        if ($urandom_range(0, 9) == 0) w = -w;
        it.seg = pack_seg(near_w(w), near_w(w), near_w(w), w, 0, 0, 0, 0);
        if (p < 38) it.seg[255:128] = it.seg[127:0];
        else begin
          if ($urandom_range(0, 3) != 0) w = int'($urandom_range(1, 1 << 20));
          it.seg[255:128] = 128'(pack_seg(near_w(w), near_w(w), near_w(w), w,
                                          0, 0, 0, 0));
        end
      end
      seg_q = {seg_q, it};
    end
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    while (seg_q.size() != 0 || s_tvalid || clipped_q.size() != 0) @(posedge clk);
    repeat (120) @(posedge clk);
    if (errors == 0 && pause_done) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/hlc_pkg.sv
rtl/hlc_frac_div.sv
rtl/hlc_front.sv
rtl/hlc_queue.sv
rtl/hlc_back.sv
rtl/homogeneous_line_clipper_top.sv
rtl/hlc_checker.sv
sim/homogeneous_line_clipper_top_test.sv
